// File: rtl/core/fpr_pkg.sv
// fifo page replacement: shared types and constants
// used by fpr_cell and fifo_page_replacement_top, no dependencies
package fpr_pkg;

	localparam int unsigned FRAMES_RESET = 3;
	localparam int unsigned CFG_W        = 5;
	localparam int unsigned PORT_PAGE_W  = 16;
	localparam int unsigned FAULT_W      = 32;

	typedef logic [FAULT_W-1:0] fault_cnt_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

// File: rtl/core/fpr_cell.sv
// fifo page replacement: one frame cell of the shifting frame chain
// holds one resident page, takes its neighbor's page on a fault
// depends on fpr_pkg
module fpr_cell import fpr_pkg::*; #(
	parameter int IDX       = 0,
	parameter int PAGE_BITS = 16,
	parameter int CW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [CW-1:0]        nf,
	input  logic [PAGE_BITS-1:0] key,
	input  logic [PAGE_BITS-1:0] prev_page,
	input  logic                 prev_valid,
	output logic [PAGE_BITS-1:0] page,
	output logic                 valid,
	output logic                 match,
	output logic                 tail_valid,
	output logic [PAGE_BITS-1:0] tail_page
);

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX_N  = CW'(IDX + 1);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 in_range;
	logic                 is_tail;

	assign in_range = (IDX_C < nf);
	assign is_tail  = (IDX_N == nf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid & in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			page_q <= prev_page;
		end
	end

	assign page       = page_q;
	assign valid      = valid_q;
	assign match      = valid_q && (page_q == key);
	assign tail_valid = valid_q & is_tail;
	assign tail_page  = tail_valid ? page_q : '0;

endmodule

// File: rtl/core/fifo_page_replacement_top.sv
// fifo page replacement: top level, frame chain, fault counter, result register
// instantiates fpr_cell, depends on fpr_pkg
//
// channel   dir  handshake              word
// in        in   in_valid / in_stall    page_number, end_of_string
// out       out  out_valid / out_stall  page_fault, evicted_valid, evicted_page, fault_total
// cfg       in   cfg_we                 frames_in_use
//
// one word per cycle unless in_stall: lookup on all cells and chain shift in the same cycle
// result appears in the cycle after the input word is taken, held in an output register
// in_stall is high only while a result waits under out_stall
// reset clears all frames, the fault count and sets the frame count to three
// a frame count write or an end_of_string word clears frames and fault count
module fifo_page_replacement_top import fpr_pkg::*; #(
	parameter int MAX_FRAME_COUNT = 16,
	parameter int PAGE_BITS       = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PORT_PAGE_W-1:0] page_number,
	input  logic                   end_of_string,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   page_fault,
	output logic                   evicted_valid,
	output logic [PORT_PAGE_W-1:0] evicted_page,
	output logic [FAULT_W-1:0]     fault_total,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       frames_in_use
);

	localparam int CW = $clog2(MAX_FRAME_COUNT + 1);
	localparam int unsigned MAXU = MAX_FRAME_COUNT;
	localparam logic [CW-1:0] NF_RST = CW'((FRAMES_RESET > MAXU) ? MAXU : FRAMES_RESET);

	logic [CW-1:0]        nf_q;
	logic [CW-1:0]        nf_wr;
	fault_cnt_t           fault_q;
	fault_cnt_t           fault_nxt;
	logic                 accept;
	logic                 miss;
	logic [PAGE_BITS-1:0] key;
	cell_ctrl_t           ctrl;

	logic [PAGE_BITS-1:0] page_a [MAX_FRAME_COUNT];
	logic [PAGE_BITS-1:0] tpage_a [MAX_FRAME_COUNT];
	logic [MAX_FRAME_COUNT-1:0] valid_vec;
	logic [MAX_FRAME_COUNT-1:0] match_vec;
	logic [MAX_FRAME_COUNT-1:0] tail_vec;
	logic [PAGE_BITS-1:0] tail_page;

	logic                   out_valid_q;
	logic                   page_fault_q;
	logic                   evicted_valid_q;
	logic [PORT_PAGE_W-1:0] evicted_page_q;
	fault_cnt_t             fault_total_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign key      = PAGE_BITS'(page_number);
	assign miss     = ~(|match_vec);

	assign ctrl.shift = accept & miss;
	assign ctrl.clear = cfg_we | (accept & end_of_string);

	// frame chain, cell zero takes the new page
	for (genvar i = 0; i < MAX_FRAME_COUNT; i++) begin : g_cell
		logic [PAGE_BITS-1:0] prev_page;
		logic                 prev_valid;
		if (i == 0) begin : g_head
			assign prev_page  = key;
			assign prev_valid = 1'b1;
		end else begin : g_link
			assign prev_page  = page_a[i-1];
			assign prev_valid = valid_vec[i-1];
		end
		fpr_cell #(
			.IDX       (i),
			.PAGE_BITS (PAGE_BITS),
			.CW        (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.nf         (nf_q),
			.key        (key),
			.prev_page  (prev_page),
			.prev_valid (prev_valid),
			.page       (page_a[i]),
			.valid      (valid_vec[i]),
			.match      (match_vec[i]),
			.tail_valid (tail_vec[i]),
			.tail_page  (tpage_a[i])
		);
	end

	always_comb begin
		tail_page = '0;
		for (int i = 0; i < MAX_FRAME_COUNT; i++) begin
			tail_page = tail_page | tpage_a[i];
		end
	end

	always_comb begin
		if (frames_in_use == '0) begin
			nf_wr = CW'(1);
		end else if (int'(frames_in_use) > MAX_FRAME_COUNT) begin
			nf_wr = CW'(MAX_FRAME_COUNT);
		end else begin
			nf_wr = CW'(frames_in_use);
		end
	end

	always_comb begin
		fault_nxt = fault_q;
		if (miss && (fault_q != '1)) begin
			fault_nxt = fault_q + FAULT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q    <= NF_RST;
			fault_q <= '0;
		end else if (cfg_we) begin
			nf_q    <= nf_wr;
			fault_q <= '0;
		end else if (accept) begin
			fault_q <= end_of_string ? '0 : fault_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_fault_q    <= miss;
			evicted_valid_q <= miss & (|tail_vec);
			evicted_page_q  <= (miss && (|tail_vec)) ? PORT_PAGE_W'(tail_page) : '0;
			fault_total_q   <= fault_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign page_fault    = page_fault_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_total_q;

	// resident frames always form a prefix of the chain
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + MAX_FRAME_COUNT'(1)) & valid_vec) == '0)
		else $error("frame valid bits not contiguous");

	a_within_nf: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec >> nf_q) == '0)
		else $error("frame valid beyond frame count");

	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_string) |=> (valid_vec == '0) && (fault_q == '0))
		else $error("end of string did not clear frames");

	a_hit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !miss && !end_of_string && !cfg_we) |=> $stable(valid_vec))
		else $error("hit changed frames");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_valid_q) |-> page_fault_q)
		else $error("eviction without fault");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench for fifo_page_replacement_top: drives page references and frame count writes
// and checks each result word against an in-bench fifo replacement predictor
// depends on fpr_pkg and the rtl of fifo_page_replacement_top
module tb;
	import fpr_pkg::*;

	localparam int FRAME_SLOTS = 16;

	typedef struct packed {
		logic                   fault;
		logic                   ev_valid;
		logic [PORT_PAGE_W-1:0] ev_page;
		fault_cnt_t             total;
	} lookup_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [PORT_PAGE_W-1:0] page_number = '0;
	logic                   end_of_string = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   page_fault;
	logic                   evicted_valid;
	logic [PORT_PAGE_W-1:0] evicted_page;
	logic [FAULT_W-1:0]     fault_total;
	logic                   cfg_we = 1'b0;
	logic [CFG_W-1:0]       frames_in_use = CFG_W'(FRAMES_RESET);

	fifo_page_replacement_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page_number   (page_number),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.page_fault    (page_fault),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total),
		.cfg_we        (cfg_we),
		.frames_in_use (frames_in_use)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [CFG_W-1:0]       frame_cfg = CFG_W'(FRAMES_RESET);
	logic [PORT_PAGE_W-1:0] slot_page [FRAME_SLOTS];
	logic                   slot_valid [FRAME_SLOTS];
	int                     slots_filled;
	int                     oldest;
	fault_cnt_t             fault_run;

	lookup_t pending_lookups [$];

	int mismatches = 0;
	int words_checked = 0;
	int faults_seen = 0;
	int evictions_seen = 0;
	int settings_used = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          hold_req = 0;
	int          hold_left = 0;
	int          stall_tick = 0;

	function automatic void flush_frames();
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_page[i] = '0;
		end
		slots_filled = 0;
		oldest = 0;
		fault_run = '0;
	endfunction

	function automatic lookup_t predict_lookup(logic [PORT_PAGE_W-1:0] page, logic last);
		lookup_t r;
		int nf;
		int cfg_v;
		int slot;
		bit hit;
		r = '0;
		hit = 1'b0;
		cfg_v = int'(frame_cfg);
		if (cfg_v == 0)
			nf = 1;
		else if (cfg_v > FRAME_SLOTS)
			nf = FRAME_SLOTS;
		else
			nf = cfg_v;
		for (int i = 0; i < nf; i++)
			if (slot_valid[i] && slot_page[i] == page)
				hit = 1'b1;
		if (!hit) begin
			if (fault_run != '1)
				fault_run = fault_run + FAULT_W'(1);
			if (slots_filled < nf) begin
				slot_page[slots_filled] = page;
				slot_valid[slots_filled] = 1'b1;
				slots_filled++;
			end else begin
				slot = oldest % nf;
				r.ev_valid = 1'b1;
				r.ev_page = slot_page[slot];
				slot_page[slot] = page;
				slot_valid[slot] = 1'b1;
				oldest = (slot + 1) % nf;
			end
		end
		r.fault = !hit;
		r.total = fault_run;
		if (last)
			flush_frames();
		return r;
	endfunction

	initial flush_frames();

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		stall_tick++;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:    out_stall <= 1'b0;
				STALL_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PATTERN: out_stall <= ((stall_tick % 7) < 3);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	task automatic report(string field, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		lookup_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lookups.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, actual %0b %0b %0h %0h",
					$time, page_fault, evicted_valid, evicted_page, fault_total);
			end else begin
				exp_w = pending_lookups.pop_front();
				report("page_fault", 32'(exp_w.fault), 32'(page_fault));
				report("evicted_valid", 32'(exp_w.ev_valid), 32'(evicted_valid));
				report("evicted_page", 32'(exp_w.ev_page), 32'(evicted_page));
				report("fault_total", exp_w.total, fault_total);
				words_checked++;
				if (page_fault)
					faults_seen++;
				if (evicted_valid)
					evictions_seen++;
			end
		end
	end

	task automatic send_word(logic [PORT_PAGE_W-1:0] page, logic last);
		in_valid <= 1'b1;
		page_number <= page;
		end_of_string <= last;
		do
			@(posedge clk);
		while (in_stall);
		pending_lookups.push_back(predict_lookup(page, last));
	endtask

	task automatic pause_input(int cycles);
		in_valid <= 1'b0;
		page_number <= PORT_PAGE_W'($urandom);
		end_of_string <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_frame_count(logic [CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		frames_in_use <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_cfg = value;
		flush_frames();
		settings_used++;
	endtask

	task automatic test_reset_frames();
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hAAAA, 1'b0);
		send_word(16'h5555, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h5555, 1'b1);
		send_word(16'hFFFF, 1'b0);
	endtask

	task automatic test_zero_frame_count();
		write_frame_count(5'd0);
		send_word(16'h1234, 1'b0);
		send_word(16'h1234, 1'b0);
		send_word(16'h4321, 1'b0);
		send_word(16'h1234, 1'b1);
	endtask

	task automatic test_rewrite_clears();
		write_frame_count(5'd2);
		send_word(16'h8001, 1'b0);
		send_word(16'h0001, 1'b0);
		write_frame_count(5'd2);
		send_word(16'h8001, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h7FFE, 1'b1);
	endtask

	task automatic test_backpressure();
		write_frame_count(5'd4);
		stall_mode = STALL_NONE;
		hold_req = 300;
		for (int i = 0; i < 48; i++)
			send_word(PORT_PAGE_W'($urandom_range(0, 7)), (i == 30));
		drain();
	endtask

	task automatic test_random_strings();
		logic [CFG_W-1:0]       cfg_list [14];
		logic [PORT_PAGE_W-1:0] work_set [32];
		logic [PORT_PAGE_W-1:0] page;
		int set_size;
		int burst_left;
		bit gaps_on;
		cfg_list = '{5'd1, 5'd2, 5'd3, 5'd16, 5'd5, 5'd8, 5'd31, 5'd12,
			5'd15, 5'd17, 5'd0, 5'd16, 5'd7, 5'd1};
		for (int ph = 0; ph < 14; ph++) begin
			write_frame_count((ph == 13) ? CFG_W'($urandom) : cfg_list[ph]);
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			set_size = $urandom_range(1, 32);
			for (int k = 0; k < 32; k++)
				work_set[k] = PORT_PAGE_W'($urandom);
			burst_left = $urandom_range(1, 20);
			for (int n = 0; n < 110; n++) begin
				if ($urandom_range(0, 19) == 0)
					work_set[$urandom_range(0, set_size - 1)] = PORT_PAGE_W'($urandom);
				if ($urandom_range(0, 99) < 85)
					page = work_set[$urandom_range(0, set_size - 1)];
				else
					page = PORT_PAGE_W'($urandom);
				send_word(page, ($urandom_range(0, 29) == 0));
				burst_left--;
				if (burst_left == 0) begin
					if (gaps_on)
						pause_input($urandom_range(1, 6));
					burst_left = $urandom_range(1, 20);
				end
			end
		end
		stall_mode = STALL_NONE;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frames();
		test_zero_frame_count();
		test_rewrite_clears();
		test_backpressure();
		test_random_strings();
		drain();
		repeat (5) @(posedge clk);
		$display("checked %0d result words: %0d faults, %0d evictions", words_checked,
			faults_seen, evictions_seen);
		$display("frame count written %0d times, including 0, 1, 16 and values above 16",
			settings_used);
		if (mismatches == 0)
			$display("PASS fifo_page_replacement_top");
		else
			$display("FAIL fifo_page_replacement_top");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d words outstanding", pending_lookups.size());
		$display("FAIL fifo_page_replacement_top");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_cell.sv
rtl/core/fifo_page_replacement_top.sv
sim/tb.sv
